/* rtl/core/buvs_pkg.sv */
// Shared types and constants for the bounded unique value set.
package buvs_pkg;

   localparam int CAPACITY    = 64;
   localparam int VALUE_WIDTH = 32;
   localparam int IDX_W       = $clog2(CAPACITY);
   localparam int CNT_W       = $clog2(CAPACITY + 1);

   localparam logic [1:0] OP_INSERT = 2'd0;
   localparam logic [1:0] OP_ERASE  = 2'd1;
   localparam logic [1:0] OP_READ   = 2'd2;

   localparam logic [CNT_W-1:0] CAP_MAX = CNT_W'(CAPACITY);

   typedef struct packed {
      logic [1:0]               op;
      logic signed [31:0]       item_value;
      logic [5:0]               read_index;
   } req_word_type;

   typedef struct packed {
      logic                     success;
      logic [6:0]               entry_total;
      logic signed [31:0]       read_value;
   } rsp_word_type;

   // Broadcast from the sequencer to every cell.
   typedef struct packed {
      logic                     cmp_en;
      logic                     erase_en;
      logic                     insert_en;
      logic [VALUE_WIDTH-1:0]   value;
      logic [IDX_W-1:0]         read_index;
      logic [CNT_W-1:0]         count;
   } ctrl_type;

endpackage

/* rtl/core/buvs_cell.sv */
// One storage cell of the set: holds an entry, matches it, shifts it down on erase.
module buvs_cell (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic [buvs_pkg::IDX_W-1:0]             cell_index,
   input  buvs_pkg::ctrl_type                     ctrl,
   input  logic                                   found_in,
   input  logic [buvs_pkg::VALUE_WIDTH-1:0]       next_value,
   output logic                                   found_out,
   output logic                                   match,
   output logic [buvs_pkg::VALUE_WIDTH-1:0]       value,
   output logic [buvs_pkg::VALUE_WIDTH-1:0]       read_part
);

   logic [buvs_pkg::VALUE_WIDTH-1:0] value_ff, value_in;
   logic                             match_ff, match_in;
   logic                             occupied;
   logic [buvs_pkg::CNT_W-1:0]       index_wide;

   assign index_wide = buvs_pkg::CNT_W'(cell_index);
   assign occupied   = index_wide < ctrl.count;
   assign found_out  = found_in | match_ff;

   always_comb begin
      match_in = match_ff;
      if (ctrl.cmp_en) begin
         match_in = occupied && (value_ff == ctrl.value);
      end
   end

   always_comb begin
      value_in = value_ff;
      if (ctrl.erase_en && found_out) begin
         value_in = next_value;
      end else if (ctrl.insert_en && (index_wide == ctrl.count)) begin
         value_in = ctrl.value;
      end
   end

   always_ff @(posedge clock) begin
      value_ff <= value_in;
      if (reset) begin
         match_ff <= 1'b0;
      end else begin
         match_ff <= match_in;
      end
   end

   assign match     = match_ff;
   assign value     = value_ff;
   assign read_part = (cell_index == ctrl.read_index) ? value_ff : '0;

endmodule

/* rtl/core/bounded_unique_value_set.sv */
// Top level of the bounded unique value set: sequencer, output register, cell row.
//
// Usage:
//   req_valid/req_stall/req_word carry one command word (insert, erase, read).
//   A word is accepted when req_valid is high and req_stall is low.
//   rsp_valid/rsp_stall/rsp_word return exactly one result word per command.
//   csr_write_enable/csr_write_data set the capacity limit (reset 64);
//   values above 64 act as 64. Write it only while the block is idle.
// Sequence:
//   Accept cycle, a compare state in which every cell matches its entry
//   against the value, then an update state in which the cell row shifts
//   on erase, appends on insert, and the result word is loaded.
//   The result is registered when the update state ends; that state waits while
//   the output slot is held, and a new command is accepted only once back in idle.
// Reset:
//   Clears the entry count, the sequencer and the output valid flag.
// Stall:
//   The output register holds its word while rsp_stall is high; one more
//   command can be accepted and compared, then the update waits for the slot.
module bounded_unique_value_set (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_valid,
   output logic                       req_stall,
   input  buvs_pkg::req_word_type     req_word,
   output logic                       rsp_valid,
   input  logic                       rsp_stall,
   output buvs_pkg::rsp_word_type     rsp_word,
   input  logic                       csr_write_enable,
   input  logic [6:0]                 csr_write_data
);

   typedef enum logic [2:0] {
      ST_IDLE = 3'b001,
      ST_CMP  = 3'b010,
      ST_UPD  = 3'b100
   } state_type;

   localparam int N  = buvs_pkg::CAPACITY;
   localparam int VW = buvs_pkg::VALUE_WIDTH;

   state_type                   state_ff, state_in;
   buvs_pkg::req_word_type      cmd_ff, cmd_in;
   logic [buvs_pkg::CNT_W-1:0]  count_ff, count_in;
   logic [6:0]                  cap_ff, cap_in;
   logic                        rsp_valid_ff, rsp_valid_in;
   buvs_pkg::rsp_word_type      rsp_word_ff, rsp_word_in;

   buvs_pkg::ctrl_type          ctrl;
   logic                        accept, slot_free, upd_go, any_match, ins_ok, rd_ok;
   logic [buvs_pkg::CNT_W-1:0]  eff_cap;
   logic [N:0]                  found;
   logic [N-1:0]                match;
   logic [VW-1:0]               value [N];
   logic [VW-1:0]               read_part [N];
   logic [VW-1:0]               read_or;

   assign req_stall = (state_ff != ST_IDLE);
   assign accept    = req_valid && !req_stall;
   assign slot_free = !rsp_valid_ff || !rsp_stall;
   assign upd_go    = (state_ff == ST_UPD) && slot_free;

   assign eff_cap   = (buvs_pkg::CNT_W'(cap_ff) > buvs_pkg::CAP_MAX) ?
                      buvs_pkg::CAP_MAX : buvs_pkg::CNT_W'(cap_ff);
   assign any_match = |match;
   assign ins_ok    = (count_ff < eff_cap) && !any_match;
   assign rd_ok     = buvs_pkg::CNT_W'(cmd_ff.read_index) < count_ff;

   always_comb begin
      ctrl.cmp_en     = (state_ff == ST_CMP);
      ctrl.erase_en   = upd_go && (cmd_ff.op == buvs_pkg::OP_ERASE);
      ctrl.insert_en  = upd_go && (cmd_ff.op == buvs_pkg::OP_INSERT) && ins_ok;
      ctrl.value      = VW'(cmd_ff.item_value);
      ctrl.read_index = cmd_ff.read_index;
      ctrl.count      = count_ff;
   end

   assign found[0] = 1'b0;

   for (genvar g = 0; g < N; g++) begin : g_cell
      logic [VW-1:0] next_value;
      if (g == N - 1) begin : g_last
         assign next_value = value[g];
      end else begin : g_mid
         assign next_value = value[g+1];
      end
      buvs_cell u_cell (
         .clock      (clock),
         .reset      (reset),
         .cell_index (buvs_pkg::IDX_W'(g)),
         .ctrl       (ctrl),
         .found_in   (found[g]),
         .next_value (next_value),
         .found_out  (found[g+1]),
         .match      (match[g]),
         .value      (value[g]),
         .read_part  (read_part[g])
      );
   end

   always_comb begin
      read_or = '0;
      for (int i = 0; i < N; i++) begin
         read_or = read_or | read_part[i];
      end
   end

   always_comb begin
      state_in     = state_ff;
      cmd_in       = cmd_ff;
      count_in     = count_ff;
      cap_in       = cap_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_word_in  = rsp_word_ff;
      if (csr_write_enable) begin
         cap_in = csr_write_data;
      end
      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               cmd_in   = req_word;
               state_in = ST_CMP;
            end
         end
         ST_CMP: begin
            state_in = ST_UPD;
         end
         ST_UPD: begin
            if (slot_free) begin
               rsp_word_in.success    = 1'b0;
               rsp_word_in.read_value = '0;
               priority if (cmd_ff.op == buvs_pkg::OP_INSERT) begin
                  if (ins_ok) begin
                     rsp_word_in.success = 1'b1;
                     count_in            = count_ff + buvs_pkg::CNT_W'(1);
                  end
               end else if (cmd_ff.op == buvs_pkg::OP_ERASE) begin
                  if (any_match) begin
                     rsp_word_in.success = 1'b1;
                     count_in            = count_ff - buvs_pkg::CNT_W'(1);
                  end
               end else if (cmd_ff.op == buvs_pkg::OP_READ) begin
                  if (rd_ok) begin
                     rsp_word_in.success    = 1'b1;
                     rsp_word_in.read_value = 32'(read_or);
                  end
               end else begin
                  rsp_word_in.success = 1'b0;
               end
               rsp_word_in.entry_total = 7'(count_in);
               rsp_valid_in            = 1'b1;
               state_in                = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      cmd_ff      <= cmd_in;
      rsp_word_ff <= rsp_word_in;
      if (reset) begin
         state_ff     <= ST_IDLE;
         count_ff     <= '0;
         cap_ff       <= 7'd64;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         cap_ff       <= cap_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_word  = rsp_word_ff;

endmodule
